@@ rtl/srrw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

   localparam int SEQ_W  = 32;
   localparam int SLOT_W = 16;
   localparam int LEN_W  = 11;
   localparam int WIN_W  = 6;

   localparam logic KIND_PACKET  = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   localparam logic [1:0] OUT_ACK     = 2'd0;
   localparam logic [1:0] OUT_NAK     = 2'd1;
   localparam logic [1:0] OUT_DELIVER = 2'd2;
   localparam logic [1:0] OUT_STATUS  = 2'd3;

   localparam logic CSR_WINDOW = 1'b0;
   localparam logic CSR_BUFFER = 1'b1;

   typedef struct packed {
      logic             shift;
      logic             set;
      logic [WIN_W-1:0] set_off;
      logic             trim;
      logic [WIN_W-1:0] trim_lim;
   } cell_ctrl_type;

   typedef struct packed {
      logic [1:0]        out_kind;
      logic [SEQ_W-1:0]  seq_number;
      logic [SLOT_W-1:0] slot;
      logic              store_payload;
      logic [LEN_W-1:0]  length;
      logic              done_res;
      logic              last;
   } rsp_type;

endpackage

@@ rtl/srrw_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw channel interfaces
// Packet request, result and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface srrw_req_if import srrw_pkg::*; ;
   logic             valid;
   logic             ready;
   logic             kind;
   logic [SEQ_W-1:0] seq;
   logic             checksum_ok;
   logic [LEN_W-1:0] data_len;
   modport source (output valid, kind, seq, checksum_ok, data_len, input ready);
   modport sink (input valid, kind, seq, checksum_ok, data_len, output ready);
endinterface

interface srrw_rsp_if import srrw_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [1:0]        out_kind;
   logic [SEQ_W-1:0]  seq_number;
   logic [SLOT_W-1:0] slot;
   logic              store_payload;
   logic [LEN_W-1:0]  length;
   logic              done_res;
   logic              last;
   modport source (output valid, out_kind, seq_number, slot, store_payload, length,
                   done_res, last, input ready);
   modport sink (input valid, out_kind, seq_number, slot, store_payload, length,
                 done_res, last, output ready);
endinterface

interface srrw_csr_if import srrw_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              index;
   logic [SLOT_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/srrw_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_cell
// One received-mask cell; shifts toward the left edge on each delivery.
// ----------------------------------------------------------------------------
module srrw_cell import srrw_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          right_bit,
   output logic          bit_out
);

   localparam logic [WIN_W-1:0] MY_IDX = WIN_W'(INDEX);

   logic bit_ff;
   logic bit_in;

   always_comb begin
      if (ctrl.trim && (MY_IDX >= ctrl.trim_lim)) begin
         bit_in = 1'b0;
      end else if (ctrl.shift) begin
         bit_in = right_bit;
      end else begin
         bit_in = bit_ff | (ctrl.set && (ctrl.set_off == MY_IDX));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 1'b0;
      end else begin
         bit_ff <= bit_in;
      end
   end

   assign bit_out = bit_ff;

endmodule

@@ rtl/srrw_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_div
// Restoring remainder unit: 32-bit value modulo a 16-bit divisor, one bit
// per cycle.
// ----------------------------------------------------------------------------
module srrw_div import srrw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SEQ_W-1:0]  dividend,
   input  logic [SLOT_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [SLOT_W-1:0] remainder
);

   logic [SEQ_W-1:0]  dvd_ff;
   logic [SLOT_W-1:0] dsr_ff;
   logic [SLOT_W-1:0] rem_ff;
   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [SLOT_W:0]   shifted;
   logic [SLOT_W:0]   diff;
   logic [SLOT_W-1:0] rem_in;

   always_comb begin
      shifted = {rem_ff, dvd_ff[SEQ_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = (shifted >= {1'b0, dsr_ff}) ? diff[SLOT_W-1:0] : shifted[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= dividend;
            dsr_ff  <= (divisor == '0) ? SLOT_W'(1) : divisor;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= {dvd_ff[SEQ_W-2:0], 1'b0};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ rtl/selective_repeat_receive_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a selective-repeat sliding window with in-order delivery.
// ----------------------------------------------------------------------------
// One item is handled at a time. A timeout, a NAK or an ACK below the left edge
// passes through the decide and push states to a registered result, and a good
// packet beyond the window top gives no result of its own. A good packet inside
// the window waits for the 32-step remainder unit that computes its payload
// slot before its ACK is pushed, and then each in-order frame is delivered in
// turn; the delivery slot follows the left edge by increment. A write of the
// slot-count register starts a recomputation of the left-edge slot during which
// no packet is taken.
module selective_repeat_receive_window import srrw_pkg::*; #(
   parameter int MAX_WINDOW  = 32,
   parameter int FRAME_BYTES = 1024
) (
   input  logic  clock,
   input  logic  reset,
   srrw_req_if.sink   req_ch,
   srrw_rsp_if.source rsp_ch,
   srrw_csr_if.sink   csr_ch
);

   localparam logic [WIN_W-1:0] MAX_W6  = WIN_W'(MAX_WINDOW);
   localparam logic [16:0]      FRAME_L = 17'(FRAME_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_WAIT, S_PUSH, S_DELIVER, S_RECALC
   } state_type;

   function automatic logic [WIN_W-1:0] eff_win(input logic [WIN_W-1:0] v);
      logic [WIN_W-1:0] r;
      if (v == '0) begin
         r = WIN_W'(1);
      end else if (v > MAX_W6) begin
         r = MAX_W6;
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type         state_ff;
   logic [WIN_W-1:0]  window_ff;
   logic [SLOT_W-1:0] buffer_ff;
   logic [SEQ_W-1:0]  left_ff;
   logic [SEQ_W-1:0]  end_seq_ff;
   logic [LEN_W-1:0]  end_len_ff;
   logic              end_seen_ff;
   logic [SLOT_W-1:0] left_slot_ff;
   logic              it_kind_ff;
   logic [SEQ_W-1:0]  it_seq_ff;
   logic              it_ok_ff;
   logic [LEN_W-1:0]  it_len_ff;
   rsp_type           pend_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [MAX_WINDOW:0] chain;
   cell_ctrl_type       cell_ctrl;
   logic [WIN_W-1:0]    win;
   logic [SEQ_W-1:0]    right;
   logic                in_win;
   logic                below;
   logic [WIN_W-1:0]    off;
   logic [16:0]         len_sat;
   logic                short_frame;
   logic [SLOT_W-1:0]   beff;
   logic [SLOT_W-1:0]   slot_inc;
   logic [SEQ_W-1:0]    left_nx;
   logic                edge_gt;
   logic                done_cur;
   logic                done_dlv;
   logic [LEN_W-1:0]    dlv_len;
   logic                out_free;
   logic                req_take;
   logic                csr_win;
   logic                csr_buf;
   logic                store_go;
   logic                div_start;
   logic [SEQ_W-1:0]    div_dividend;
   logic [SLOT_W-1:0]   div_divisor;
   logic                div_busy;
   logic                div_done;
   logic [SLOT_W-1:0]   div_rem;

   always_comb begin
      win         = eff_win(window_ff);
      right       = left_ff + SEQ_W'(win);
      in_win      = (it_seq_ff < right) && (it_seq_ff >= left_ff);
      below       = (it_seq_ff < right) && (it_seq_ff < left_ff);
      off         = it_seq_ff[WIN_W-1:0] - left_ff[WIN_W-1:0];
      len_sat     = ({6'b0, it_len_ff} > FRAME_L) ? FRAME_L : {6'b0, it_len_ff};
      short_frame = len_sat < FRAME_L;
      beff        = (buffer_ff == '0) ? SLOT_W'(1) : buffer_ff;
      slot_inc    = ((left_ff == '1) || (({1'b0, left_slot_ff} + 17'd1) >= {1'b0, beff}))
                    ? '0 : left_slot_ff + SLOT_W'(1);
      left_nx     = left_ff + SEQ_W'(1);
      edge_gt     = left_ff > end_seq_ff;
      done_cur    = end_seen_ff && edge_gt;
      done_dlv    = end_seen_ff && (left_nx > end_seq_ff);
      dlv_len     = (end_seen_ff && (left_ff == end_seq_ff)) ? end_len_ff : FRAME_L[LEN_W-1:0];
      out_free    = !rsp_valid_ff || rsp_ch.ready;
      req_take    = req_ch.valid && !csr_ch.valid && (state_ff == S_IDLE);
      csr_win     = csr_ch.valid && (csr_ch.index == CSR_WINDOW);
      csr_buf     = csr_ch.valid && (csr_ch.index == CSR_BUFFER);
      store_go    = (state_ff == S_DECIDE) && (it_kind_ff == KIND_PACKET) && it_ok_ff
                    && in_win;

      div_start    = store_go || csr_buf;
      div_dividend = csr_buf ? left_ff : it_seq_ff;
      div_divisor  = csr_buf ? csr_ch.wdata : beff;

      cell_ctrl.shift    = (state_ff == S_DELIVER) && out_free;
      cell_ctrl.set      = store_go;
      cell_ctrl.set_off  = off;
      cell_ctrl.trim     = csr_win;
      cell_ctrl.trim_lim = eff_win(csr_ch.wdata[WIN_W-1:0]);
   end

   assign chain[MAX_WINDOW] = 1'b0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      srrw_cell #(.INDEX(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .right_bit (chain[i+1]),
         .bit_out   (chain[i])
      );
   end

   srrw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         window_ff    <= WIN_W'(8);
         buffer_ff    <= SLOT_W'(32);
         left_ff      <= '0;
         end_seq_ff   <= '0;
         end_len_ff   <= '0;
         end_seen_ff  <= 1'b0;
         left_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_win) begin
            window_ff <= csr_ch.wdata[WIN_W-1:0];
         end
         if (csr_buf) begin
            buffer_ff <= csr_ch.wdata;
         end
         if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  it_kind_ff <= req_ch.kind;
                  it_seq_ff  <= req_ch.seq;
                  it_ok_ff   <= req_ch.checksum_ok;
                  it_len_ff  <= req_ch.data_len;
                  state_ff   <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               pend_ff.slot          <= '0;
               pend_ff.store_payload <= 1'b0;
               pend_ff.length        <= '0;
               pend_ff.last          <= !chain[0];
               if (it_kind_ff == KIND_TIMEOUT) begin
                  if (edge_gt) begin
                     end_seen_ff <= 1'b1;
                  end
                  pend_ff.out_kind   <= OUT_STATUS;
                  pend_ff.seq_number <= left_ff;
                  pend_ff.done_res   <= edge_gt;
                  state_ff           <= S_PUSH;
               end else if (!it_ok_ff) begin
                  pend_ff.out_kind   <= OUT_NAK;
                  pend_ff.seq_number <= it_seq_ff;
                  pend_ff.done_res   <= done_cur;
                  state_ff           <= S_PUSH;
               end else if (in_win) begin
                  if (short_frame) begin
                     end_seq_ff  <= it_seq_ff;
                     end_len_ff  <= len_sat[LEN_W-1:0];
                     end_seen_ff <= 1'b1;
                  end else if (it_seq_ff > end_seq_ff) begin
                     end_seq_ff <= it_seq_ff;
                     end_len_ff <= FRAME_L[LEN_W-1:0];
                  end
                  pend_ff.out_kind   <= OUT_ACK;
                  pend_ff.seq_number <= it_seq_ff;
                  state_ff           <= S_WAIT;
               end else if (below) begin
                  pend_ff.out_kind   <= OUT_ACK;
                  pend_ff.seq_number <= it_seq_ff;
                  pend_ff.done_res   <= done_cur;
                  state_ff           <= S_PUSH;
               end else begin
                  state_ff <= chain[0] ? S_DELIVER : S_IDLE;
               end
            end
            S_WAIT: begin
               if (div_done) begin
                  pend_ff.slot          <= div_rem;
                  pend_ff.store_payload <= 1'b1;
                  pend_ff.length        <= len_sat[LEN_W-1:0];
                  pend_ff.done_res      <= done_cur;
                  pend_ff.last          <= !chain[0];
                  state_ff              <= S_PUSH;
               end
            end
            S_PUSH: begin
               if (out_free) begin
                  rsp_ff       <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= pend_ff.last ? S_IDLE : S_DELIVER;
               end
            end
            S_DELIVER: begin
               if (out_free) begin
                  rsp_ff.out_kind      <= OUT_DELIVER;
                  rsp_ff.seq_number    <= left_ff;
                  rsp_ff.slot          <= left_slot_ff;
                  rsp_ff.store_payload <= 1'b0;
                  rsp_ff.length        <= dlv_len;
                  rsp_ff.done_res      <= done_dlv;
                  rsp_ff.last          <= !chain[1];
                  rsp_valid_ff         <= 1'b1;
                  left_ff              <= left_nx;
                  left_slot_ff         <= slot_inc;
                  if (!chain[1]) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            S_RECALC: begin
               if (div_done) begin
                  left_slot_ff <= div_rem;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (csr_buf) begin
            state_ff <= S_RECALC;
         end
      end
   end

   assign req_ch.ready         = (state_ff == S_IDLE) && !csr_ch.valid;
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.out_kind      = rsp_ff.out_kind;
   assign rsp_ch.seq_number    = rsp_ff.seq_number;
   assign rsp_ch.slot          = rsp_ff.slot;
   assign rsp_ch.store_payload = rsp_ff.store_payload;
   assign rsp_ch.length        = rsp_ff.length;
   assign rsp_ch.done_res      = rsp_ff.done_res;
   assign rsp_ch.last          = rsp_ff.last;

   a_take_decide: assert property (@(posedge clock) disable iff (reset)
      (req_take && !csr_buf) |=> (state_ff == S_DECIDE))
      else $error("accepted transfer did not reach decode");

   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (div_busy || div_done))
      else $error("waiting on an idle remainder unit");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (left_slot_ff < beff))
      else $error("left-edge slot outside the buffer");

endmodule
